@@ rtl/tstg_pkg.sv @@
// Shared commands, constants and the sine table builder for the tone generator.
package tstg_pkg;

  typedef logic [1:0] cmd_t;

  localparam cmd_t CMD_START  = 2'd0;
  localparam cmd_t CMD_SAMPLE = 2'd1;
  localparam cmd_t CMD_TICK   = 2'd2;
  localparam cmd_t CMD_NONE   = 2'd3;

  localparam int unsigned AMP_W    = 15;
  localparam int unsigned OUT_W    = 16;
  localparam logic [14:0] AMP_RESET = 15'd842;

  // pi/2 in Q30 radians.
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // Denominators of the odd Taylor terms: (2k)(2k+1) for k = 1..7.
  localparam longint unsigned TAYLOR_DIV [7] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210
  };

  // Quarter-wave sine entry q of a table with 2^tb entries, Q15, built at elaboration.
  function automatic logic [14:0] sine_q15(int unsigned q, int unsigned tb);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    longint unsigned r;
    x    = (longint'(q) * HALF_PI_Q30 + (64'd1 << (tb - 3))) >> (tb - 2);
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int k = 0; k < 7; k++) begin
      term = ((term * x2) >> 30) / TAYLOR_DIV[k];
      if ((k % 2) == 0) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    r = (longint'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
    if (r > 64'd32767) begin
      r = 64'd32767;
    end
    return r[14:0];
  endfunction

endpackage

@@ rtl/timed_sine_tone_generator_top.sv @@
// Timed sine tone generator: phase accumulator, sine table, amplitude scaling.
//
// Usage: the input stream carries commands in in_tuser (start, sample request,
// one-millisecond tick). A start transfer loads the phase step and duration
// from in_tdata, clears the phase and elapsed time and starts the tone. Each
// sample request while the tone plays returns the sine at the current phase,
// scaled by the amplitude register, then advances the phase. Ticks count
// elapsed milliseconds; the tone stops on the tick at which elapsed reaches
// the duration. Every input transfer yields exactly one output transfer that
// carries the sample in out_tdata and the valid and running flags in out_tuser.
// Each input passes stage A, then the output register. One item is taken every
// cycle unless the receiver stalls, set by one table read and one 15x15 multiply.
// The APB port holds the amplitude at byte address 0 (reset value 842).
// Reset stops the tone and clears phase, step, elapsed time and duration.
// When the receiver stalls, the output register and one internal stage hold
// their results and in_tready drops once both are full; nothing is lost.
module timed_sine_tone_generator_top #(
  parameter int TABLE_BITS   = 10,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [63:0]           in_tdata,   // tone_step [31:0], duration_ms [63:32]
  input  tstg_pkg::cmd_t        in_tuser,   // cmd [1:0]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [15:0]           out_tdata,  // sample [15:0]
  output logic [1:0]            out_tuser,  // sample_valid [0], running [1]
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [2:0]            cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);
  import tstg_pkg::*;

  localparam int QTR_N = 1 << (TABLE_BITS - 2);
  localparam logic [TABLE_BITS-2:0] QTR_SIZE = (TABLE_BITS - 1)'(QTR_N);
  localparam int UP = (SAMPLE_WIDTH > 16) ? SAMPLE_WIDTH - 16 : 0;
  localparam int DN = (SAMPLE_WIDTH < 16) ? 16 - SAMPLE_WIDTH : 0;

  // Quarter-wave table, constant logic computed at elaboration.
  logic [14:0] qtab [QTR_N + 1];
  for (genvar g = 0; g <= QTR_N; g++) begin : g_qtab
    assign qtab[g] = sine_q15(g, TABLE_BITS);
  end

  // Configuration.
  logic [AMP_W-1:0] amplitude_r;
  logic             cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == 1'b0) ? {17'd0, amplitude_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amplitude_r <= AMP_RESET;
    end else if (cfg_wr && cfg_paddr[2] == 1'b0) begin
      amplitude_r <= cfg_pwdata[AMP_W-1:0];
    end
  end

  // Oscillator state.
  logic [31:0] phase_acc_r, phase_acc_nxt;
  logic [31:0] step_r, step_nxt;
  logic [31:0] elapsed_r, elapsed_nxt;
  logic [31:0] duration_r, duration_nxt;
  logic        playing_r, playing_nxt;
  logic [31:0] elapsed_inc;

  // Stage A holds the table magnitude; the output register holds the result.
  logic        a_valid_r;
  logic [14:0] a_mag_r, a_mag_nxt;
  logic        a_neg_r, a_neg_nxt;
  logic        a_sv_r, a_sv_nxt;
  logic        a_run_r;

  logic        out_valid_r;
  logic [15:0] out_data_r, out_data_nxt;
  logic [1:0]  out_user_r;

  logic in_acc;
  logic adv;

  assign adv       = !out_valid_r || out_tready;
  assign in_tready = !a_valid_r || adv;
  assign in_acc    = in_tvalid && in_tready;

  // Table lookup at the current phase.
  logic [TABLE_BITS-1:0] idx;
  logic [1:0]            quad;
  logic [TABLE_BITS-2:0] pos;

  assign idx  = phase_acc_r[31 -: TABLE_BITS];
  assign quad = idx[TABLE_BITS-1 -: 2];
  assign pos  = quad[0] ? (QTR_SIZE - {1'b0, idx[TABLE_BITS-3:0]})
                        : {1'b0, idx[TABLE_BITS-3:0]};

  assign elapsed_inc = (elapsed_r == 32'hFFFF_FFFF) ? elapsed_r : elapsed_r + 32'd1;

  always_comb begin
    phase_acc_nxt = phase_acc_r;
    step_nxt      = step_r;
    elapsed_nxt   = elapsed_r;
    duration_nxt  = duration_r;
    playing_nxt   = playing_r;
    a_mag_nxt     = 15'd0;
    a_neg_nxt     = 1'b0;
    a_sv_nxt      = 1'b0;
    unique case (in_tuser)
      CMD_START: begin
        step_nxt      = in_tdata[31:0];
        duration_nxt  = in_tdata[63:32];
        phase_acc_nxt = 32'd0;
        elapsed_nxt   = 32'd0;
        playing_nxt   = 1'b1;
      end
      CMD_SAMPLE: begin
        if (playing_r) begin
          a_mag_nxt     = qtab[pos];
          a_neg_nxt     = quad[1];
          a_sv_nxt      = 1'b1;
          phase_acc_nxt = phase_acc_r + step_r;
        end
      end
      CMD_TICK: begin
        if (playing_r) begin
          elapsed_nxt = elapsed_inc;
          if (elapsed_inc >= duration_r) begin
            playing_nxt = 1'b0;
          end
        end
      end
      CMD_NONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_acc_r <= 32'd0;
      step_r      <= 32'd0;
      elapsed_r   <= 32'd0;
      duration_r  <= 32'd0;
      playing_r   <= 1'b0;
    end else if (in_acc) begin
      phase_acc_r <= phase_acc_nxt;
      step_r      <= step_nxt;
      elapsed_r   <= elapsed_nxt;
      duration_r  <= duration_nxt;
      playing_r   <= playing_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_acc) begin
      a_valid_r <= 1'b1;
    end else if (adv) begin
      a_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_mag_r <= a_mag_nxt;
      a_neg_r <= a_neg_nxt;
      a_sv_r  <= a_sv_nxt;
      a_run_r <= playing_nxt;
    end
  end

  // Scaling: magnitude times amplitude, Q15, then fitted to the sample width.
  logic [29:0] prod;
  logic [31:0] scaled;

  assign prod   = 30'(a_mag_r) * 30'(amplitude_r);
  assign scaled = ({17'd0, prod[29:15]} << UP) >> DN;

  assign out_data_nxt = a_neg_r ? 16'(32'd0 - scaled) : scaled[15:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && a_valid_r) begin
      out_data_r <= out_data_nxt;
      out_user_r <= {a_run_r, a_sv_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

`ifndef SYNTHESIS
  // A result without a tone sample carries a zero sample.
  a_zero_when_no_sample: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == 16'd0)
    else $error("sample not zero on a result without a tone sample");

  // A stalled output keeps the internal stage occupied.
  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    a_valid_r && out_tvalid && !out_tready |=> a_valid_r)
    else $error("internal stage dropped an item during a stall");

  // A start transfer sets the tone running.
  a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tuser == CMD_START |=> playing_r)
    else $error("tone not running after a start transfer");

  // A sample request while stopped leaves the phase alone.
  a_phase_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tuser == CMD_SAMPLE && !playing_r |=> $stable(phase_acc_r))
    else $error("phase moved on a sample request while stopped");
`endif

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for the timed sine tone generator with its own tone predictor.
module testbench;
  import tstg_pkg::*;

  localparam int TABLE_BITS = 10;
  localparam int QUARTER = 1 << (TABLE_BITS - 2);
  localparam logic [2:0] REG_AMPLITUDE = 3'd0;
  localparam int LATENCY = 4;

  typedef struct packed {
    logic [15:0] sample;
    logic        sample_valid;
    logic        running;
  } tone_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;   // tone_step [31:0], duration_ms [63:32]
  cmd_t        in_tuser;   // cmd [1:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // sample [15:0]
  logic [1:0]  out_tuser;  // sample_valid [0], running [1]
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  timed_sine_tone_generator_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // Predictor state, mirrored from the block.
  logic [14:0]  quarter_sine [0:QUARTER];
  logic [14:0]  amplitude;
  logic [31:0]  phase_acc;
  logic [31:0]  step_reg;
  logic [31:0]  elapsed_ms;
  logic [31:0]  duration_reg;
  logic         playing;
  tone_result_t expected_samples [$];
  int           failures;
  int           items_sent;
  bit           tx_steady;
  bit           rx_steady;

  // Taylor series through x^15 on a Q30 angle, rounded half up to Q15.
  function automatic logic [14:0] quarter_sine_q15(int unsigned q);
    longint unsigned angle;
    longint unsigned angle_sq;
    longint unsigned term;
    longint unsigned rounded;
    longint          acc;
    angle = 64'(q);
    angle = (angle * HALF_PI_Q30 + QUARTER / 2) / QUARTER;
    angle_sq = (angle * angle) >> 30;
    term = angle;
    acc = longint'(angle);
    for (int k = 1; k <= 7; k++) begin
      term = ((term * angle_sq) >> 30) / longint'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    rounded = ($unsigned(acc) * 64'd32767 + (64'd1 << 29)) >> 30;
    if (rounded > 64'd32767) begin
      rounded = 64'd32767;
    end
    return rounded[14:0];
  endfunction

  function automatic tone_result_t predict_tone_result(cmd_t cmd, logic [31:0] step,
                                                       logic [31:0] dur);
    tone_result_t res;
    logic [TABLE_BITS-1:0] idx;
    logic [1:0]            quad;
    int unsigned           pos;
    logic [31:0]           mag;
    res = '0;
    case (cmd)
      CMD_START: begin
        step_reg = step;
        duration_reg = dur;
        phase_acc = '0;
        elapsed_ms = '0;
        playing = 1'b1;
      end
      CMD_SAMPLE: begin
        if (playing) begin
          idx = phase_acc[31 -: TABLE_BITS];
          quad = idx[TABLE_BITS-1 -: 2];
          pos = 32'(idx[TABLE_BITS-3:0]);
          if (quad[0]) begin
            pos = QUARTER - pos;
          end
          mag = (32'(quarter_sine[pos]) * 32'(amplitude)) >> 15;
          res.sample = quad[1] ? (16'd0 - mag[15:0]) : mag[15:0];
          res.sample_valid = 1'b1;
          phase_acc = phase_acc + step_reg;
        end
      end
      CMD_TICK: begin
        if (playing) begin
          if (elapsed_ms != '1) begin
            elapsed_ms = elapsed_ms + 1;
          end
          if (elapsed_ms >= duration_reg) begin
            playing = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
    res.running = playing;
    return res;
  endfunction

  function automatic logic [31:0] random_tone_step();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'd0;
      2, 3: return $urandom_range(0, 20000) * 32'd134218;  // audio range steps
      default: return $urandom & 32'h7FFF_FFFF;
    endcase
  endfunction

  function automatic logic [31:0] random_duration();
    case ($urandom_range(0, 11))
      0: return $urandom;
      1: return 32'hFFFF_FFFF;
      default: return $urandom_range(0, 12);
    endcase
  endfunction

  task automatic send_command(cmd_t cmd, logic [31:0] step, logic [31:0] dur);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser = cmd;
    in_tdata = {dur, step};
    do @(posedge clk); while (!in_tready);
    expected_samples.push_back(predict_tone_result(cmd, step, dur));
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_tvalid = 1'b0;
    while (expected_samples.size() != 0) @(negedge clk);
    repeat (LATENCY) @(negedge clk);
  endtask

  // Writes the amplitude register while the block is idle and reads it back.
  task automatic write_amplitude(logic [14:0] value);
    wait_idle();
    cfg_psel = 1'b1;
    cfg_pwrite = 1'b1;
    cfg_penable = 1'b0;
    cfg_paddr = REG_AMPLITUDE;
    cfg_pwdata = {17'd0, value};
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    amplitude = value;
    @(negedge clk);
    cfg_pwrite = 1'b0;
    cfg_penable = 1'b0;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== {17'd0, value}) begin
      $error("amplitude readback: expected %0d, got %0d", value, cfg_prdata);
      failures++;
    end
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
  endtask

  task automatic test_idle_commands();
    send_command(CMD_SAMPLE, '1, '1);
    send_command(CMD_TICK, '0, '0);
    send_command(CMD_NONE, '1, '0);
  endtask

  // Quarter-turn steps land on zero, both peaks and wrap back to zero.
  task automatic test_quarter_points();
    write_amplitude(15'h7FFF);
    send_command(CMD_START, 32'h4000_0000, 32'd2);
    repeat (5) send_command(CMD_SAMPLE, '0, '0);
    send_command(CMD_NONE, '0, '0);
    send_command(CMD_TICK, '0, '0);
    send_command(CMD_TICK, '0, '0);
    send_command(CMD_SAMPLE, '0, '0);
  endtask

  task automatic test_duration_and_restart();
    send_command(CMD_START, 32'h8000_0000, 32'd0);
    send_command(CMD_SAMPLE, '0, '0);
    send_command(CMD_SAMPLE, '0, '0);
    send_command(CMD_TICK, '0, '0);
    send_command(CMD_START, 32'd1, 32'hFFFF_FFFF);
    send_command(CMD_SAMPLE, '0, '0);
    send_command(CMD_START, 32'h7FFF_FFFF, 32'd1);
    repeat (3) send_command(CMD_SAMPLE, '0, '0);
    send_command(CMD_TICK, '0, '0);
  endtask

  // Mostly start-then-play sequences with random content, some stray commands.
  task automatic run_random_tones(int count);
    int target;
    int len;
    int pick;
    target = items_sent + count;
    while (items_sent < target) begin
      tx_steady = ($urandom_range(0, 5) == 0);
      rx_steady = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 9) == 0) begin
        send_command(cmd_t'($urandom_range(1, 3)), $urandom, $urandom);
      end else begin
        send_command(CMD_START, random_tone_step(), random_duration());
        len = $urandom_range(1, 40);
        repeat (len) begin
          pick = $urandom_range(0, 9);
          if (pick < 6) begin
            send_command(CMD_SAMPLE, $urandom, $urandom);
          end else if (pick < 9) begin
            send_command(CMD_TICK, $urandom, $urandom);
          end else begin
            send_command(CMD_NONE, $urandom, $urandom);
          end
        end
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin : result_checker
    tone_result_t want;
    int stall;
    out_tready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      stall = rx_steady ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        out_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
      if (expected_samples.size() == 0) begin
        $error("result with none expected: sample %0d", $signed(out_tdata));
        failures++;
      end else begin
        want = expected_samples.pop_front();
        if (out_tdata !== want.sample) begin
          $error("sample: expected %0d, got %0d", $signed(want.sample), $signed(out_tdata));
          failures++;
        end
        if (out_tuser[0] !== want.sample_valid) begin
          $error("sample_valid: expected %0b, got %0b", want.sample_valid, out_tuser[0]);
          failures++;
        end
        if (out_tuser[1] !== want.running) begin
          $error("running: expected %0b, got %0b", want.running, out_tuser[1]);
          failures++;
        end
      end
      @(negedge clk);
    end
  end

  initial begin
    #400000;
    $display("timed_sine_tone_generator_top: mismatch");
    $finish;
  end

  initial begin
    for (int q = 0; q <= QUARTER; q++) begin
      quarter_sine[q] = quarter_sine_q15(q);
    end
    amplitude = 15'd842;
    phase_acc = '0;
    step_reg = '0;
    elapsed_ms = '0;
    duration_reg = '0;
    playing = 1'b0;
    failures = 0;
    items_sent = 0;
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = CMD_NONE;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_idle_commands();
    test_quarter_points();
    test_duration_and_restart();
    write_amplitude(15'h7FFF);
    run_random_tones(350);
    write_amplitude(15'd0);
    run_random_tones(150);
    write_amplitude(15'd1);
    run_random_tones(150);
    write_amplitude(15'($urandom));
    run_random_tones(400);
    write_amplitude(15'($urandom));
    run_random_tones(400);

    wait_idle();
    repeat (4 * LATENCY) @(negedge clk);
    if (failures == 0 && expected_samples.size() == 0) begin
      $display("timed_sine_tone_generator_top: match");
    end else begin
      $display("timed_sine_tone_generator_top: mismatch");
    end
    $finish;
  end

endmodule
